// ===== rtl/core/single_block_writeback_cache_assert.svh =====
// Assertion macros for the single-block write-back cache.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SINGLE_BLOCK_WRITEBACK_CACHE_ASSERT_SVH
`define SINGLE_BLOCK_WRITEBACK_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBWBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBWBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache check failed");

`endif

// ===== rtl/core/sbwbc_pkg.sv =====
// Shared types and codes for the single-block write-back cache.
// No dependencies.
`timescale 1ns / 1ps

package sbwbc_pkg;

    typedef enum logic [2:0] {
        KIND_READ_DATA  = 3'd0,
        KIND_WRITE_DONE = 3'd1,
        KIND_WB_WORD    = 3'd2,
        KIND_FILL_REQ   = 3'd3,
        KIND_FAILED     = 3'd4,
        KIND_BUSY       = 3'd5
    } kind_t;

    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_FILL   = 3'd2;
    localparam logic [2:0] CMD_STATUS = 3'd3;
    localparam logic [2:0] CMD_FLUSH  = 3'd4;

    localparam int TAG_BITS  = 23;
    localparam int WIDX_BITS = 6;

endpackage

// ===== rtl/core/single_block_writeback_cache.sv =====
// Top level of the single-block write-back cache: line memory, tag and control.
// Depends on sbwbc_pkg and single_block_writeback_cache_assert.svh.
`timescale 1ns / 1ps

// The first result of a word appears in the cycle after the word is accepted and stays on the
// ports for one cycle; the receiver cannot hold it off. Hits do not raise busy and may be
// issued back to back. A writeback streams one word per cycle from the line memory, so busy
// stays high while the remaining words stream after the access or flush that starts it. The
// last fill word is followed by a busy state, ST_CMPL, in which the held access reads or
// writes the line memory; its result is registered from that state. The configuration channel
// is always ready. BLOCK_BYTES must be a power of two; the block itself does not enforce it.

`include "single_block_writeback_cache_assert.svh"

module single_block_writeback_cache
    import sbwbc_pkg::*;
#(
    parameter int BLOCK_BYTES = 512,
    parameter int ADDR_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           cmd,
    input  logic [31:0]          byte_address,
    input  logic [7:0]           write_byte,
    input  logic                 request_end,
    input  logic [63:0]          fill_word,
    input  logic                 backing_ok,
    output logic                 result_valid,
    output logic [2:0]           kind,
    output logic [TAG_BITS-1:0]  block_number,
    output logic [63:0]          payload,
    output logic [WIDX_BITS-1:0] word_index,
    output logic                 run_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    localparam int OFF_BITS   = $clog2(BLOCK_BYTES);
    localparam int WORD_BITS  = OFF_BITS - 3;
    localparam int LINE_WORDS = BLOCK_BYTES / 8;
    localparam int AW         = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam logic [31:0] ADDR_MASK =
        (AW >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << AW) - 64'd1);
    localparam logic [WORD_BITS-1:0] LAST_WORD = WORD_BITS'(LINE_WORDS - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WB_WAIT,
        PH_FILL,
        PH_FLUSH_WAIT
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WB,
        ST_CMPL
    } state_t;

    typedef enum logic [1:0] {
        PSEL_ZERO,
        PSEL_BYTE,
        PSEL_WORD
    } psel_t;

    function automatic logic [TAG_BITS-1:0] block_of(input logic [31:0] a);
        logic [31:0] shifted;
        shifted = a >> OFF_BITS;
        return shifted[TAG_BITS-1:0];
    endfunction

    logic [63:0] line_mem [LINE_WORDS];
    logic [63:0] rdata_reg;

    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_waddr;
    logic [63:0]          mem_wdata;
    logic [7:0]           mem_be;
    logic [WORD_BITS-1:0] mem_raddr;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [TAG_BITS-1:0]  line_tag_reg, line_tag_next;
    logic                 line_valid_reg, line_valid_next;
    logic                 line_dirty_reg, line_dirty_next;
    logic [WORD_BITS-1:0] fill_cnt_reg, fill_cnt_next;
    logic [WORD_BITS-1:0] wb_cnt_reg, wb_cnt_next;
    logic                 aborting_reg, aborting_next;
    logic                 mounted_reg, mounted_next;
    logic                 held_wr_reg, held_wr_next;
    logic                 held_end_reg, held_end_next;
    logic [7:0]           held_byte_reg, held_byte_next;
    logic [31:0]          held_addr_reg, held_addr_next;

    logic                 result_valid_reg, result_valid_next;
    kind_t                kind_reg, kind_next;
    logic [TAG_BITS-1:0]  block_reg, block_next;
    logic [WIDX_BITS-1:0] word_index_reg, word_index_next;
    logic                 run_last_reg, run_last_next;
    psel_t                psel_reg, psel_next;
    logic [2:0]           lane_reg, lane_next;

    logic                 accept;
    logic [31:0]          in_addr;
    logic [WORD_BITS-1:0] in_word;
    logic [2:0]           in_lane;
    logic [TAG_BITS-1:0]  in_blk;
    logic                 in_hit;
    logic [WORD_BITS-1:0] held_word;
    logic [2:0]           held_lane;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign in_addr   = byte_address & ADDR_MASK;
    assign in_word   = in_addr[OFF_BITS-1:3];
    assign in_lane   = in_addr[2:0];
    assign in_blk    = block_of(in_addr);
    assign in_hit    = line_valid_reg && (line_tag_reg == in_blk);
    assign held_word = held_addr_reg[OFF_BITS-1:3];
    assign held_lane = held_addr_reg[2:0];

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        line_tag_next     = line_tag_reg;
        line_valid_next   = line_valid_reg;
        line_dirty_next   = line_dirty_reg;
        fill_cnt_next     = fill_cnt_reg;
        wb_cnt_next       = wb_cnt_reg;
        aborting_next     = aborting_reg;
        mounted_next      = cfg_valid ? cfg_data : mounted_reg;
        held_wr_next      = held_wr_reg;
        held_end_next     = held_end_reg;
        held_byte_next    = held_byte_reg;
        held_addr_next    = held_addr_reg;
        result_valid_next = 1'b0;
        kind_next         = kind_reg;
        block_next        = '0;
        word_index_next   = '0;
        run_last_next     = 1'b1;
        psel_next         = PSEL_ZERO;
        lane_next         = lane_reg;
        mem_we            = 1'b0;
        mem_waddr         = in_word;
        mem_wdata         = {8{write_byte}};
        mem_be            = 8'b1 << in_lane;
        mem_raddr         = in_word;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_READ, CMD_WRITE:
                        begin
                            result_valid_next = 1'b1;
                            if (phase_reg != PH_IDLE)
                            begin
                                kind_next = KIND_BUSY;
                            end
                            else if (aborting_reg)
                            begin
                                kind_next = KIND_FAILED;
                                if (request_end)
                                begin
                                    aborting_next = 1'b0;
                                end
                            end
                            else if (!mounted_reg)
                            begin
                                kind_next     = KIND_FAILED;
                                aborting_next = !request_end;
                            end
                            else if (in_hit)
                            begin
                                if (cmd == CMD_WRITE)
                                begin
                                    mem_we          = 1'b1;
                                    line_dirty_next = 1'b1;
                                    kind_next       = KIND_WRITE_DONE;
                                end
                                else
                                begin
                                    kind_next = KIND_READ_DATA;
                                    psel_next = PSEL_BYTE;
                                    lane_next = in_lane;
                                end
                            end
                            else
                            begin
                                held_wr_next   = (cmd == CMD_WRITE);
                                held_end_next  = request_end;
                                held_byte_next = write_byte;
                                held_addr_next = in_addr;
                                if (line_valid_reg && line_dirty_reg)
                                begin
                                    mem_raddr     = '0;
                                    state_next    = ST_WB;
                                    wb_cnt_next   = WORD_BITS'(1);
                                    phase_next    = PH_WB_WAIT;
                                    kind_next     = KIND_WB_WORD;
                                    block_next    = line_tag_reg;
                                    psel_next     = PSEL_WORD;
                                    run_last_next = 1'b0;
                                end
                                else
                                begin
                                    line_valid_next = 1'b0;
                                    line_dirty_next = 1'b0;
                                    fill_cnt_next   = '0;
                                    phase_next      = PH_FILL;
                                    kind_next       = KIND_FILL_REQ;
                                    block_next      = in_blk;
                                end
                            end
                        end
                        CMD_FILL:
                        begin
                            if (phase_reg == PH_FILL)
                            begin
                                if (!backing_ok)
                                begin
                                    line_valid_next   = 1'b0;
                                    phase_next        = PH_IDLE;
                                    fill_cnt_next     = '0;
                                    result_valid_next = 1'b1;
                                    kind_next         = KIND_FAILED;
                                    aborting_next     = !held_end_reg;
                                end
                                else
                                begin
                                    mem_we        = 1'b1;
                                    mem_waddr     = fill_cnt_reg;
                                    mem_wdata     = fill_word;
                                    mem_be        = 8'hFF;
                                    fill_cnt_next = fill_cnt_reg + WORD_BITS'(1);
                                    if (fill_cnt_reg == LAST_WORD)
                                    begin
                                        fill_cnt_next   = '0;
                                        phase_next      = PH_IDLE;
                                        line_valid_next = 1'b1;
                                        line_dirty_next = 1'b0;
                                        line_tag_next   = block_of(held_addr_reg);
                                        state_next      = ST_CMPL;
                                    end
                                end
                            end
                        end
                        CMD_STATUS:
                        begin
                            if (phase_reg == PH_WB_WAIT)
                            begin
                                result_valid_next = 1'b1;
                                if (backing_ok)
                                begin
                                    line_valid_next = 1'b0;
                                    line_dirty_next = 1'b0;
                                    fill_cnt_next   = '0;
                                    phase_next      = PH_FILL;
                                    kind_next       = KIND_FILL_REQ;
                                    block_next      = block_of(held_addr_reg);
                                end
                                else
                                begin
                                    phase_next    = PH_IDLE;
                                    kind_next     = KIND_FAILED;
                                    aborting_next = !held_end_reg;
                                end
                            end
                            else if (phase_reg == PH_FLUSH_WAIT)
                            begin
                                result_valid_next = 1'b1;
                                phase_next        = PH_IDLE;
                                if (backing_ok)
                                begin
                                    line_dirty_next = 1'b0;
                                    kind_next       = KIND_WRITE_DONE;
                                end
                                else
                                begin
                                    kind_next = KIND_FAILED;
                                end
                            end
                        end
                        CMD_FLUSH:
                        begin
                            result_valid_next = 1'b1;
                            if (phase_reg != PH_IDLE)
                            begin
                                kind_next = KIND_BUSY;
                            end
                            else if (!mounted_reg)
                            begin
                                kind_next = KIND_FAILED;
                            end
                            else if (line_valid_reg && line_dirty_reg)
                            begin
                                mem_raddr     = '0;
                                state_next    = ST_WB;
                                wb_cnt_next   = WORD_BITS'(1);
                                phase_next    = PH_FLUSH_WAIT;
                                kind_next     = KIND_WB_WORD;
                                block_next    = line_tag_reg;
                                psel_next     = PSEL_WORD;
                                run_last_next = 1'b0;
                            end
                            else
                            begin
                                kind_next = KIND_WRITE_DONE;
                            end
                        end
                        default:
                        begin
                            result_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_WB:
            begin
                mem_raddr         = wb_cnt_reg;
                result_valid_next = 1'b1;
                kind_next         = KIND_WB_WORD;
                block_next        = line_tag_reg;
                word_index_next   = WIDX_BITS'(wb_cnt_reg);
                psel_next         = PSEL_WORD;
                run_last_next     = (wb_cnt_reg == LAST_WORD);
                wb_cnt_next       = wb_cnt_reg + WORD_BITS'(1);
                if (wb_cnt_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMPL:
            begin
                mem_raddr         = held_word;
                result_valid_next = 1'b1;
                state_next        = ST_IDLE;
                if (held_wr_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = held_word;
                    mem_wdata       = {8{held_byte_reg}};
                    mem_be          = 8'b1 << held_lane;
                    line_dirty_next = 1'b1;
                    kind_next       = KIND_WRITE_DONE;
                end
                else
                begin
                    kind_next = KIND_READ_DATA;
                    psel_next = PSEL_BYTE;
                    lane_next = held_lane;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (mem_we && mem_be[i])
            begin
                line_mem[mem_waddr][i*8 +: 8] <= mem_wdata[i*8 +: 8];
            end
        end
        rdata_reg <= line_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_IDLE;
            line_tag_reg     <= '0;
            line_valid_reg   <= 1'b0;
            line_dirty_reg   <= 1'b0;
            fill_cnt_reg     <= '0;
            wb_cnt_reg       <= '0;
            aborting_reg     <= 1'b0;
            mounted_reg      <= 1'b0;
            held_wr_reg      <= 1'b0;
            held_end_reg     <= 1'b0;
            held_byte_reg    <= '0;
            held_addr_reg    <= '0;
            result_valid_reg <= 1'b0;
            kind_reg         <= KIND_READ_DATA;
            block_reg        <= '0;
            word_index_reg   <= '0;
            run_last_reg     <= 1'b0;
            psel_reg         <= PSEL_ZERO;
            lane_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            line_tag_reg     <= line_tag_next;
            line_valid_reg   <= line_valid_next;
            line_dirty_reg   <= line_dirty_next;
            fill_cnt_reg     <= fill_cnt_next;
            wb_cnt_reg       <= wb_cnt_next;
            aborting_reg     <= aborting_next;
            mounted_reg      <= mounted_next;
            held_wr_reg      <= held_wr_next;
            held_end_reg     <= held_end_next;
            held_byte_reg    <= held_byte_next;
            held_addr_reg    <= held_addr_next;
            result_valid_reg <= result_valid_next;
            kind_reg         <= kind_next;
            block_reg        <= block_next;
            word_index_reg   <= word_index_next;
            run_last_reg     <= run_last_next;
            psel_reg         <= psel_next;
            lane_reg         <= lane_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign block_number = block_reg;
    assign word_index   = word_index_reg;
    assign run_last     = run_last_reg;

    always_comb
    begin
        case (psel_reg)
            PSEL_WORD: payload = rdata_reg;
            PSEL_BYTE: payload = {56'd0, rdata_reg[{lane_reg, 3'b000} +: 8]};
            default:   payload = '0;
        endcase
    end

    `SBWBC_ASSERT_NEXT(a_wb_stream, state_reg == ST_WB,
        result_valid && (kind == KIND_WB_WORD))
    `SBWBC_ASSERT_SAME(a_wb_last, result_valid && (kind == KIND_WB_WORD) && run_last,
        word_index == WIDX_BITS'(LAST_WORD))
    `SBWBC_ASSERT_SAME(a_dirty_valid, line_dirty_reg, line_valid_reg)
    `SBWBC_ASSERT_SAME(a_fill_invalid, phase_reg == PH_FILL, !line_valid_reg)

endmodule
